// ===== rtl/pid_flag_mask_table_assert.svh =====
// ----------------------------------------------------------------------------
// pid_flag_mask_table assertion macros
// Clocked assertion wrappers; build with ASSERT_OFF defined to drop them.
// ----------------------------------------------------------------------------
`ifndef PID_FLAG_MASK_TABLE_ASSERT_SVH
`define PID_FLAG_MASK_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PFMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pid_flag_mask_table: assertion failed");
`define PFMT_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pid_flag_mask_table: forbidden condition seen");
`else
`define PFMT_ASSERT(lbl, clk, rst, prop)
`define PFMT_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== rtl/pfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pfmt_pkg
// Transaction types, command codes and table entry layout.
// ----------------------------------------------------------------------------
package pfmt_pkg;

   localparam logic [1:0] MODE_HIDE       = 2'd0;
   localparam logic [1:0] MODE_UNHIDE     = 2'd1;
   localparam logic [1:0] MODE_UNHIDE_ALL = 2'd2;
   localparam logic [1:0] MODE_QUERY      = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] pid;
      logic [31:0] type_mask;
   } req_type;

   typedef struct packed {
      logic       hidden;
      logic       was_found;
      logic       full_reject;
      logic [5:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] flags;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/pfmt_ram.sv =====
// ----------------------------------------------------------------------------
// pfmt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfmt_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pid_flag_mask_table.sv =====
// ----------------------------------------------------------------------------
// pid_flag_mask_table
// Table of process IDs, each holding a 32-bit flag mask, kept in one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command reads
// the whole table once through the RAM read port (one entry per cycle, with
// registered read data), closes the scan, then writes back at most one
// entry. The result shows on rsp_data for one cycle with rsp_valid; busy
// drops in that same cycle, so the next command can already be taken in it,
// but not while one is still in progress. The receiver must take the result
// when it appears. Unhide-all clears each entry right after the scan reads
// it, so it costs no extra time. After reset the block sweeps every RAM
// entry to mark it free, with busy high.
// ----------------------------------------------------------------------------
`include "pid_flag_mask_table_assert.svh"

module pid_flag_mask_table
   import pfmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   req_type       req_ff, req_in;
   logic          dvalid_ff, dvalid_in;
   logic [AW-1:0] didx_ff, didx_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]   hit_flags_ff, hit_flags_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [CW-1:0] used_ff, used_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry;
   entry_type           wr_entry;
   logic                issue;
   logic [31:0]         new_flags;
   logic [CW+5:0]       used_ext;

   pfmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry  = entry_type'(ram_rdata);
   assign ram_wdata = ENTRY_W'(wr_entry);
   assign ram_raddr = cnt_ff[AW-1:0];
   assign issue     = (state_ff == ST_SCAN) && (cnt_ff != CW'(TABLE_ENTRIES));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      dvalid_in    = 1'b0;
      didx_in      = cnt_ff[AW-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_flags_in = hit_flags_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff[AW-1:0];
      wr_entry     = '0;
      new_flags    = hit_flags_ff & ~req_ff.type_mask;
      used_ext     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (cnt_ff == CW'(TABLE_ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in    = cnt_ff + 1'b1;
               dvalid_in = 1'b1;
            end
            if (dvalid_ff) begin
               if (rd_entry.valid && rd_entry.key == req_ff.pid && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = didx_ff;
                  hit_flags_in = rd_entry.flags;
               end
               if (!rd_entry.valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = didx_ff;
               end
               // unhide-all frees each entry once the scan has read it
               if (req_ff.mode == MODE_UNHIDE_ALL) begin
                  ram_we    = 1'b1;
                  ram_waddr = didx_ff;
               end
            end
            if (!issue && !dvalid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_in.hidden      = 1'b0;
            rsp_in.was_found   = hit_ff;
            rsp_in.full_reject = 1'b0;
            case (req_ff.mode)
               MODE_HIDE: begin
                  if (hit_ff) begin
                     ram_we         = 1'b1;
                     ram_waddr      = hit_idx_ff;
                     wr_entry.valid = 1'b1;
                     wr_entry.key   = req_ff.pid;
                     wr_entry.flags = hit_flags_ff | req_ff.type_mask;
                  end else if (free_ff) begin
                     ram_we         = 1'b1;
                     ram_waddr      = free_idx_ff;
                     wr_entry.valid = 1'b1;
                     wr_entry.key   = req_ff.pid;
                     wr_entry.flags = req_ff.type_mask;
                     used_in        = used_ff + 1'b1;
                  end else begin
                     rsp_in.full_reject = 1'b1;
                  end
               end
               MODE_UNHIDE: begin
                  if (hit_ff) begin
                     ram_we         = 1'b1;
                     ram_waddr      = hit_idx_ff;
                     wr_entry.valid = (new_flags != 32'd0);
                     wr_entry.key   = req_ff.pid;
                     wr_entry.flags = new_flags;
                     if (new_flags == 32'd0 && used_ff != '0) begin
                        used_in = used_ff - 1'b1;
                     end
                  end
               end
               MODE_UNHIDE_ALL: begin
                  used_in = '0;
               end
               default: begin
                  rsp_in.hidden = hit_ff &&
                     ((hit_flags_ff & req_ff.type_mask) == req_ff.type_mask);
               end
            endcase
            used_ext           = {6'd0, used_in};
            rsp_in.entry_count = used_ext[5:0];
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         dvalid_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dvalid_ff    <= dvalid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      didx_ff      <= didx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_flags_ff <= hit_flags_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PFMT_ASSERT_NEVER(a_count_range, clock, reset, used_ff > CW'(TABLE_ENTRIES))
   `PFMT_ASSERT(a_rsp_after_done, clock, reset, rsp_valid_ff |-> $past(state_ff == ST_DONE))
   `PFMT_ASSERT(a_reject_only_full, clock, reset, (rsp_valid_ff && rsp_ff.full_reject) |-> (used_ff == CW'(TABLE_ENTRIES)))
   `PFMT_ASSERT_NEVER(a_hidden_needs_hit, clock, reset, rsp_valid_ff && rsp_ff.hidden && !rsp_ff.was_found)
   `PFMT_ASSERT_NEVER(a_no_write_idle, clock, reset, (state_ff == ST_IDLE) && ram_we)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_flag_mask_table testbench
// A short directed sequence, then random command streams in three sender idle
// phases. Each phase opens with a burst that fills the table to overflow, then
// mixes runs of commands over a small key pool with fully random noise. Every
// result is checked field by field against a table model kept here.
// ----------------------------------------------------------------------------
module testbench
   import pfmt_pkg::*;
();

   localparam int TABLE_ENTRIES = 32;
   localparam int LATENCY       = TABLE_ENTRIES + 2;
   localparam int POOL_KEYS     = 40;
   localparam int PHASE_ITEMS   = 400;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct {
      req_type cmd;
      int      idle_pct;
      bit      wait_empty;
   } pending_cmd_type;

   typedef struct {
      req_type cmd;
      rsp_type rsp;
   } status_expect_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_cmd_type   command_q[$];
   status_expect_type expected_status_q[$];

   // table model
   bit          tbl_valid[TABLE_ENTRIES];
   logic [31:0] tbl_key[TABLE_ENTRIES];
   logic [31:0] tbl_flags[TABLE_ENTRIES];
   int          tbl_count = 0;

   logic [31:0] key_pool[POOL_KEYS];
   int          cur_idle_pct = 0;
   int          cycle_count = 0;
   int          error_count = 0;
   int          results_checked = 0;
   int          n_mode[4] = '{0, 0, 0, 0};
   int          n_reject = 0;
   int          n_hidden = 0;
   int          n_freed = 0;
   int          peak_count = 0;

   pid_flag_mask_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Applies one command to the table model and returns the status it yields.
   function automatic rsp_type apply_table_command(req_type cmd);
      rsp_type st;
      int      hit;
      int      free_slot;
      st = '0;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == cmd.pid) hit = i;
         if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
      end
      n_mode[cmd.mode]++;
      case (cmd.mode)
         MODE_HIDE: begin
            if (hit >= 0) begin
               tbl_flags[hit] |= cmd.type_mask;
            end else if (free_slot >= 0) begin
               tbl_valid[free_slot] = 1'b1;
               tbl_key[free_slot]   = cmd.pid;
               tbl_flags[free_slot] = cmd.type_mask;
               tbl_count++;
            end else begin
               st.full_reject = 1'b1;
               n_reject++;
            end
         end
         MODE_UNHIDE: begin
            if (hit >= 0) begin
               tbl_flags[hit] &= ~cmd.type_mask;
               if (tbl_flags[hit] == '0) begin
                  tbl_valid[hit] = 1'b0;
                  if (tbl_count > 0) tbl_count--;
                  n_freed++;
               end
            end
         end
         MODE_UNHIDE_ALL: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            tbl_count = 0;
         end
         default: begin
            if (hit >= 0 && (tbl_flags[hit] & cmd.type_mask) == cmd.type_mask) begin
               st.hidden = 1'b1;
               n_hidden++;
            end
         end
      endcase
      if (tbl_count > peak_count) peak_count = tbl_count;
      st.was_found   = (hit >= 0);
      st.entry_count = tbl_count[5:0];
      return st;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                  req_type cmd);
      $display("[%0t] mismatch %s: got %0h expected %0h (mode %0d pid %h mask %h)",
               $realtime, what, got, want, cmd.mode, cmd.pid, cmd.type_mask);
      error_count++;
   endtask

   // Driver: one nonblocking write of start per edge.
   always @(posedge clock) begin
      logic launch;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         launch = start;
         if (start && !busy) begin
            expected_status_q.push_back(status_expect_type'{cmd: req_data,
                                        rsp: apply_table_command(req_data)});
            launch = 1'b0;
         end
         if (!launch && command_q.size() != 0) begin
            if (command_q[0].wait_empty && expected_status_q.size() != 0) begin
               launch = 1'b0;
            end else if ($urandom_range(99) < command_q[0].idle_pct) begin
               launch = 1'b0;
            end else begin
               req_data <= command_q[0].cmd;
               command_q.pop_front();
               launch = 1'b1;
            end
         end
         start <= launch;
      end
   end

   // Monitor: the receiver takes every result in the cycle it appears.
   always @(posedge clock) begin
      status_expect_type want;
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            report_mismatch("rsp_valid unknown", rsp_valid, 0, req_data);
         end else if (rsp_valid) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, 0, req_data);
            end else begin
               want = expected_status_q.pop_front();
               results_checked++;
               if (rsp_data.hidden !== want.rsp.hidden)
                  report_mismatch("hidden", rsp_data.hidden, want.rsp.hidden, want.cmd);
               if (rsp_data.was_found !== want.rsp.was_found)
                  report_mismatch("was_found", rsp_data.was_found, want.rsp.was_found,
                                  want.cmd);
               if (rsp_data.full_reject !== want.rsp.full_reject)
                  report_mismatch("full_reject", rsp_data.full_reject,
                                  want.rsp.full_reject, want.cmd);
               if (rsp_data.entry_count !== want.rsp.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count,
                                  want.rsp.entry_count, want.cmd);
            end
         end
      end
   end

   task automatic add_cmd(logic [1:0] mode, logic [31:0] pid, logic [31:0] mask,
                          bit wait_empty = 1'b0);
      pending_cmd_type p;
      p.cmd.mode      = mode;
      p.cmd.pid       = pid;
      p.cmd.type_mask = mask;
      p.idle_pct      = cur_idle_pct;
      p.wait_empty    = wait_empty;
      command_q.push_back(p);
   endtask

   // Skewed toward few low bits so that unhides often empty an entry.
   function automatic logic [31:0] random_mask();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0:       return '0;
         1, 2:    return '1;
         3, 4:    return $urandom();
         5, 6, 7: return 32'd1 << $urandom_range(31);
         default: return $urandom_range(15);
      endcase
   endfunction

   // Empty the table, then hide 34 distinct pool keys: the last two overflow.
   task automatic fill_table(bit wait_empty);
      int offset;
      offset = $urandom_range(POOL_KEYS - 1);
      add_cmd(MODE_UNHIDE_ALL, key_pool[offset], random_mask(), wait_empty);
      for (int j = 0; j < TABLE_ENTRIES + 2; j++)
         add_cmd(MODE_HIDE, key_pool[(offset + j) % POOL_KEYS], random_mask());
      for (int j = 0; j < 4; j++) begin
         add_cmd(MODE_HIDE, key_pool[(offset + $urandom_range(TABLE_ENTRIES - 1)) % POOL_KEYS],
                 random_mask());
         add_cmd(MODE_QUERY, key_pool[$urandom_range(POOL_KEYS - 1)], random_mask());
      end
   endtask

   initial begin
      int phase_idle[3];
      int base;
      int burst;
      int pick;
      logic [1:0]  mode;
      logic [31:0] pid;
      phase_idle = '{0, 68, 22};

      // directed corner cases
      add_cmd(MODE_QUERY,      32'h0,        32'h0);
      add_cmd(MODE_HIDE,       32'h0,        32'h0);
      add_cmd(MODE_QUERY,      32'h0,        32'h0);
      add_cmd(MODE_QUERY,      32'h0,        32'h1);
      add_cmd(MODE_UNHIDE,     32'h0,        32'h0);
      add_cmd(MODE_QUERY,      32'h0,        32'h0);
      add_cmd(MODE_HIDE,       32'hFFFFFFFF, 32'hFFFFFFFF);
      add_cmd(MODE_QUERY,      32'hFFFFFFFF, 32'hFFFFFFFF);
      add_cmd(MODE_UNHIDE,     32'h12345678, 32'hFFFFFFFF);
      add_cmd(MODE_UNHIDE,     32'hFFFFFFFF, 32'h0000FFFF);
      add_cmd(MODE_QUERY,      32'hFFFFFFFF, 32'hFFFFFFFF);
      add_cmd(MODE_QUERY,      32'hFFFFFFFF, 32'hFFFF0000);
      add_cmd(MODE_HIDE,       32'hFFFFFFFF, 32'h00000001);
      add_cmd(MODE_UNHIDE,     32'hFFFFFFFF, 32'hFFFFFFFF);
      add_cmd(MODE_HIDE,       32'h5A5A5A5A, 32'hA5A5A5A5);
      add_cmd(MODE_HIDE,       32'h80000000, 32'h80000001);
      add_cmd(MODE_UNHIDE_ALL, 32'h5A5A5A5A, 32'hFFFFFFFF);
      add_cmd(MODE_UNHIDE_ALL, 32'h00000000, 32'h00000000);
      add_cmd(MODE_QUERY,      32'h80000000, 32'h00000000);

      for (int ph = 0; ph < 3; ph++) begin
         cur_idle_pct = phase_idle[ph];
         key_pool[0] = 32'h0;
         key_pool[1] = 32'hFFFFFFFF;
         for (int k = 2; k < POOL_KEYS; k++) key_pool[k] = $urandom();
         base = command_q.size();
         fill_table(1'b1);
         while (command_q.size() - base < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               burst = $urandom_range(60, 20);
               for (int j = 0; j < burst; j++) begin
                  pick = $urandom_range(99);
                  mode = pick < 40 ? MODE_HIDE : pick < 65 ? MODE_UNHIDE :
                         pick < 97 ? MODE_QUERY : MODE_UNHIDE_ALL;
                  pid = $urandom_range(9) == 0 ? $urandom() :
                        key_pool[$urandom_range(POOL_KEYS - 1)];
                  add_cmd(mode, pid, random_mask());
               end
            end else if (pick < 85) begin
               fill_table($urandom_range(3) == 0);
            end else begin
               for (int j = 0; j < 10; j++)
                  add_cmd(2'($urandom_range(3)), $urandom(), $urandom());
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (command_q.size() != 0 || start || expected_status_q.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("covered %0d commands (%0d hide, %0d unhide, %0d unhide-all, %0d query)",
               results_checked, n_mode[MODE_HIDE], n_mode[MODE_UNHIDE],
               n_mode[MODE_UNHIDE_ALL], n_mode[MODE_QUERY]);
      $display("%0d full-table rejects, %0d queries all set, %0d freed by unhide, peak %0d",
               n_reject, n_hidden, n_freed, peak_count);
      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pfmt_pkg.sv
rtl/pfmt_ram.sv
rtl/pid_flag_mask_table.sv
dv/testbench.sv
